@@ rtl/telnet_rx_option_negotiator_assert.svh @@
// ----------------------------------------------------------------------------
// Telnet receive negotiator assertion macros
// Shared concurrent assertion forms for the negotiator checks.
// ----------------------------------------------------------------------------
`ifndef TELNET_RX_OPTION_NEGOTIATOR_ASSERT_SVH
`define TELNET_RX_OPTION_NEGOTIATOR_ASSERT_SVH

// implication checked at every clock unless reset
`define TRN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TRN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/trn_pkg.sv @@
// ----------------------------------------------------------------------------
// Telnet receive negotiator package
// Shared types, codes and reply tables.
// ----------------------------------------------------------------------------
`default_nettype none
package trn_pkg;

   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_ESC  = 2'd1;
   localparam logic [1:0] KIND_NET  = 2'd2;

   localparam logic [7:0] IAC_BYTE = 8'hFF;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QPtrWidth  = 1;

   typedef enum logic [3:0] {
      RUN_NONE   = 4'd0,
      RUN_ONE    = 4'd1,
      RUN_THREE  = 4'd2,
      RUN_NAWS   = 4'd3,
      RUN_LMDO   = 4'd4,
      RUN_TTYPE  = 4'd5,
      RUN_SPEED  = 4'd6,
      RUN_LMSB   = 4'd7,
      RUN_ENV    = 4'd8
   } run_type;

   typedef struct packed {
      run_type    run;
      logic [1:0] kind;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic       peer_echo;
      logic       echo_off;
      logic       cr_only;
   } cmd_type;

   localparam logic [0:53][7:0] LMDO_TABLE = {
      8'hff,8'hfa,8'h22,8'h03,8'h01,
      8'h00,8'h00,8'h03,8'h62,8'h03,8'h04,8'h02,8'h0f,8'h05,8'h00,8'h00,8'h07,8'h62,
      8'h1c,8'h08,8'h02,8'h04,8'h09,8'h42,8'h1a,8'h0a,8'h02,8'h7f,8'h0b,8'h02,8'h15,
      8'h0c,8'h02,8'h17,8'h0d,8'h02,8'h12,8'h0e,8'h02,8'h16,8'h0f,8'h02,8'h11,8'h10,
      8'h02,8'h13,8'h11,8'h00,8'h00,8'h12,8'h00,8'h00,8'hff,8'hf0};
   localparam logic [0:10][7:0] TTYPE_TABLE = {
      8'hff,8'hfa,8'h18,8'h00,8'h58,8'h54,8'h45,8'h52,8'h4d,8'hff,8'hf0};
   localparam logic [0:16][7:0] SPEED_TABLE = {
      8'hff,8'hfa,8'h20,8'h00,8'h33,8'h38,8'h34,8'h30,8'h30,8'h2c,
      8'h33,8'h38,8'h34,8'h30,8'h30,8'hff,8'hf0};
   localparam logic [0:6][7:0] LMSB_TABLE = {
      8'hff,8'hfa,8'h22,8'h01,8'h17,8'hff,8'hf0};
   localparam logic [0:5][7:0] ENV_TABLE = {
      8'hff,8'hfa,8'h27,8'h00,8'hff,8'hf0};

   function automatic logic [5:0] run_length(run_type r);
      logic [5:0] len;
      unique case (r)
         RUN_ONE:   len = 6'd1;
         RUN_THREE: len = 6'd3;
         RUN_NAWS:  len = 6'd9;
         RUN_LMDO:  len = 6'd54;
         RUN_TTYPE: len = 6'd11;
         RUN_SPEED: len = 6'd17;
         RUN_LMSB:  len = 6'd7;
         RUN_ENV:   len = 6'd6;
         default:   len = 6'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] no_iac(logic [7:0] v);
      return (v == IAC_BYTE) ? 8'hFE : v;
   endfunction

endpackage
`default_nettype wire

@@ rtl/trn_req_if.sv @@
// ----------------------------------------------------------------------------
// Telnet receive byte channel
// Valid/ready channel carrying one received byte.
// ----------------------------------------------------------------------------
`default_nettype none
interface trn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/trn_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Telnet result channel
// Valid/ready channel carrying one classified output byte and flags.
// ----------------------------------------------------------------------------
`default_nettype none
interface trn_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       peer_echoes;
   logic       local_echo_off;
   logic       cr_only_mode;
   modport source (output valid, output out_kind, output out_byte, output last_of_run,
                   output peer_echoes, output local_echo_off, output cr_only_mode,
                   input ready);
   modport sink (input valid, input out_kind, input out_byte, input last_of_run,
                 input peer_echoes, input local_echo_off, input cr_only_mode,
                 output ready);
endinterface
`default_nettype wire

@@ rtl/trn_parser.sv @@
// ----------------------------------------------------------------------------
// Telnet receive parser
// Runs the phase machine on each accepted byte and issues at most one command.
// ----------------------------------------------------------------------------
`default_nettype none
module trn_parser
   import trn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   output logic            in_ready,
   input  wire logic       cmd_ready,
   output logic            cmd_valid,
   output cmd_type         cmd
);

   logic [3:0] phase_ff, phase_in;
   logic [7:0] sub0_ff, sub0_in, sub1_ff, sub1_in, sub2_ff, sub2_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pe_ff, pe_in, eo_ff, eo_in, cr_ff, cr_in;
   logic       store;
   logic [7:0] b;
   run_type    run;
   logic [1:0] kind;
   logic [7:0] o0, o1, o2;
   logic [7:0] s0, s1, s2;
   logic       fire;

   assign in_ready = cmd_ready;
   assign fire     = in_valid && cmd_ready;
   assign b        = in_byte;
   assign s0 = (cnt_ff > 2'd0) ? sub0_ff : 8'd0;
   assign s1 = (cnt_ff > 2'd1) ? sub1_ff : 8'd0;
   assign s2 = (cnt_ff > 2'd2) ? sub2_ff : 8'd0;

   always_comb begin
      phase_in = phase_ff;
      pe_in = pe_ff; eo_in = eo_ff; cr_in = cr_ff;
      run = RUN_NONE; kind = KIND_NET;
      o0 = b; o1 = 8'd0; o2 = 8'd0;
      store = 1'b0;
      sub0_in = sub0_ff; sub1_in = sub1_ff; sub2_in = sub2_ff; cnt_in = cnt_ff;
      if (b == 8'd8 || b == 8'd10 || b == 8'd11 || b == 8'd13 || b == 8'd14
          || b == 8'd15) begin
         run = RUN_ONE; kind = KIND_TEXT;
      end else begin
         unique case (phase_ff)
            4'd1: begin
               run = RUN_ONE; kind = KIND_ESC;
               if (b == "[") phase_in = 4'd2;
               else if (b == "#") phase_in = 4'd10;
               else if (b == "(") phase_in = 4'd11;
               else if (b == ")") phase_in = 4'd12;
               else if (b == "7" || b == "8" || b == "E" || b == "D" || b == "M"
                        || b == ">" || b == "=") phase_in = 4'd0;
            end
            4'd2: begin
               run = RUN_ONE; kind = KIND_ESC;
               if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) phase_in = 4'd0;
            end
            4'd3: begin
               phase_in = 4'd0;
               if (b == 8'hFB) phase_in = 4'd4;
               else if (b == 8'hFC) phase_in = 4'd5;
               else if (b == 8'hFD) phase_in = 4'd6;
               else if (b == 8'hFE) phase_in = 4'd7;
               else if (b == 8'hFA) begin
                  phase_in = 4'd8;
                  sub0_in = 8'd0; sub1_in = 8'd0; sub2_in = 8'd0; cnt_in = 2'd0;
               end else if (b == IAC_BYTE) begin
                  run = RUN_ONE; kind = KIND_TEXT;
               end
            end
            4'd4: begin
               phase_in = 4'd0;
               o0 = IAC_BYTE; o1 = 8'hFD; o2 = b;
               if (b == 8'h01) begin
                  pe_in = 1'b1; run = RUN_THREE;
               end else if (b == 8'h03) begin
                  run = RUN_THREE;
               end
            end
            4'd5: phase_in = 4'd0;
            4'd6: begin
               phase_in = 4'd0;
               o0 = IAC_BYTE; o2 = b;
               if (b == 8'h00) begin
                  run = RUN_THREE; o1 = 8'hFB;
               end else if (b == 8'h01) begin
                  run = RUN_THREE; o1 = 8'hFC; eo_in = 1'b1;
               end else if (b == 8'h1F) begin
                  run = RUN_NAWS;
               end else if (b == 8'h22) begin
                  run = RUN_LMDO;
               end else if (b == 8'h23 || b == 8'h24) begin
                  run = RUN_THREE; o1 = 8'hFC;
               end
            end
            4'd7: begin
               phase_in = 4'd0;
               o0 = IAC_BYTE; o1 = 8'hFC; o2 = b;
               if (b == 8'h22) run = RUN_THREE;
            end
            4'd8: begin
               if (b == IAC_BYTE) phase_in = 4'd9;
               else store = 1'b1;
            end
            4'd9: begin
               if (b == 8'hF0) begin
                  phase_in = 4'd0;
                  if (s0 == 8'h18 && s1 == 8'h01) run = RUN_TTYPE;
                  else if (s0 == 8'h20 && s1 == 8'h01) run = RUN_SPEED;
                  else if (s0 == 8'h22 && s1 == 8'h01 && s2 == 8'h13) begin
                     run = RUN_LMSB; cr_in = 1'b1;
                  end else if (s0 == 8'h27 && s1 == 8'h01) run = RUN_ENV;
               end else begin
                  phase_in = 4'd8;
                  store = (b == IAC_BYTE);
               end
            end
            4'd10, 4'd11, 4'd12: begin
               phase_in = 4'd0; run = RUN_ONE; kind = KIND_ESC;
            end
            default: begin
               if (b == 8'h1B) begin
                  phase_in = 4'd1; run = RUN_ONE; kind = KIND_ESC;
               end else if (b == IAC_BYTE) begin
                  phase_in = 4'd3;
               end else begin
                  phase_in = 4'd0; run = RUN_ONE; kind = KIND_TEXT;
               end
            end
         endcase
      end
      if (store && cnt_ff != 2'd3) begin
         cnt_in = cnt_ff + 2'd1;
         unique case (cnt_ff)
            2'd0: sub0_in = b;
            2'd1: sub1_in = b;
            default: sub2_in = b;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 4'd0;
         sub0_ff <= 8'd0; sub1_ff <= 8'd0; sub2_ff <= 8'd0;
         cnt_ff <= 2'd0;
         pe_ff <= 1'b0; eo_ff <= 1'b0; cr_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         sub0_ff <= sub0_in; sub1_ff <= sub1_in; sub2_ff <= sub2_in;
         cnt_ff <= cnt_in;
         pe_ff <= pe_in; eo_ff <= eo_in; cr_ff <= cr_in;
      end
   end

   assign cmd_valid     = fire && (run != RUN_NONE);
   assign cmd.run       = run;
   assign cmd.kind      = kind;
   assign cmd.b0        = o0;
   assign cmd.b1        = o1;
   assign cmd.b2        = o2;
   assign cmd.peer_echo = pe_in;
   assign cmd.echo_off  = eo_in;
   assign cmd.cr_only   = cr_in;

endmodule
`default_nettype wire

@@ rtl/trn_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// Telnet command queue
// Short FIFO between the parser and the reply sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module trn_cmd_queue
   import trn_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         not_full,
   input  wire logic    pop,
   output logic         not_empty,
   output cmd_type      head
);

   cmd_type              mem_ff [QueueDepth];
   logic [QPtrWidth-1:0] wp_ff, rp_ff;
   logic [QPtrWidth:0]   cnt_ff, cnt_in;

   assign not_full  = cnt_ff < (QPtrWidth+1)'(QueueDepth);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rp_ff];
   assign cnt_in    = cnt_ff + (QPtrWidth+1)'(push) - (QPtrWidth+1)'(pop);

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/trn_reply_seq.sv @@
// ----------------------------------------------------------------------------
// Telnet reply sequencer
// Expands one queued command into its run of output bytes.
// ----------------------------------------------------------------------------
`default_nettype none
module trn_reply_seq
   import trn_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       cmd_avail,
   input  wire cmd_type    cmd,
   output logic            cmd_pop,
   input  wire logic [7:0] window_columns,
   input  wire logic [7:0] window_rows,
   trn_rsp_if.source       rsp
);

   logic [5:0] idx_ff, idx_in;
   logic [5:0] len;
   logic [7:0] ob;
   logic       last;
   logic       take;

   assign len  = run_length(cmd.run);
   assign last = (idx_ff == len - 6'd1);
   assign take = rsp.valid && rsp.ready;
   assign cmd_pop = take && last;
   assign idx_in  = cmd_pop ? 6'd0 : idx_ff + 6'd1;

   always_comb begin
      unique case (cmd.run)
         RUN_THREE: begin
            unique case (idx_ff[1:0])
               2'd0: ob = cmd.b0;
               2'd1: ob = cmd.b1;
               default: ob = cmd.b2;
            endcase
         end
         RUN_NAWS: begin
            unique case (idx_ff[3:0])
               4'd0: ob = IAC_BYTE;
               4'd1: ob = 8'hFA;
               4'd2: ob = 8'h1F;
               4'd4: ob = no_iac(window_columns);
               4'd6: ob = no_iac(window_rows);
               4'd7: ob = IAC_BYTE;
               4'd8: ob = 8'hF0;
               default: ob = 8'h00;
            endcase
         end
         RUN_LMDO:  ob = LMDO_TABLE[idx_ff];
         RUN_TTYPE: ob = TTYPE_TABLE[idx_ff[3:0]];
         RUN_SPEED: ob = SPEED_TABLE[idx_ff[4:0]];
         RUN_LMSB:  ob = LMSB_TABLE[idx_ff[2:0]];
         RUN_ENV:   ob = ENV_TABLE[idx_ff[2:0]];
         default:   ob = cmd.b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 6'd0;
      else if (take) idx_ff <= idx_in;
   end

   assign rsp.valid          = cmd_avail;
   assign rsp.out_kind       = cmd.kind;
   assign rsp.out_byte       = ob;
   assign rsp.last_of_run    = last;
   assign rsp.peer_echoes    = cmd.peer_echo;
   assign rsp.local_echo_off = cmd.echo_off;
   assign rsp.cr_only_mode   = cmd.cr_only;

endmodule
`default_nettype wire

@@ rtl/telnet_rx_option_negotiator.sv @@
// A byte's command, if any, enters the command queue when the byte is accepted.
// One byte per cycle while each makes at most one result and rsp is ready;
// the sequencer sends each reply run byte by byte (up to 54) from one command.
// The two-entry command queue lets the parser run ahead of the sequencer.
// Reset (synchronous, active high) returns the parser to text, clears the
// flags and queue, and sets the window size to 80 by 24.
// ----------------------------------------------------------------------------
// Telnet receive option negotiator
// Parser, command queue and reply sequencer with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "telnet_rx_option_negotiator_assert.svh"
module telnet_rx_option_negotiator
   import trn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   trn_req_if.sink          req,
   trn_rsp_if.source        rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [7:0] cols_ff, rows_ff;
   logic       cmd_valid, q_not_full, q_not_empty, q_pop;
   cmd_type    cmd, head;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 8'd80; rows_ff <= 8'd24;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == 3'd0) cols_ff <= csr_pwdata[7:0];
         else if (csr_paddr == 3'd4) rows_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == 3'd0) csr_prdata = {24'd0, cols_ff};
      else if (csr_paddr == 3'd4) csr_prdata = {24'd0, rows_ff};
   end

   trn_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_byte   (req.rx_byte),
      .in_ready  (req.ready),
      .cmd_ready (q_not_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   trn_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_cmd  (cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head)
   );

   trn_reply_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cmd_avail      (q_not_empty),
      .cmd            (head),
      .cmd_pop        (q_pop),
      .window_columns (cols_ff),
      .window_rows    (rows_ff),
      .rsp            (rsp)
   );

   `TRN_ASSERT_IMP(a_no_push_full, clock, reset, cmd_valid, q_not_full,
      "command pushed into full queue")
   `TRN_ASSERT_IMP(a_pop_nonempty, clock, reset, q_pop, q_not_empty,
      "command popped from empty queue")
   `TRN_ASSERT_NEXT(a_flag_sticky, clock, reset, rsp.valid && rsp.cr_only_mode,
      !rsp.valid || rsp.cr_only_mode, "cr-only flag cleared")

endmodule
`default_nettype wire

@@ tb/sv/tb_telnet_rx_option_negotiator.sv @@
// ----------------------------------------------------------------------------
// Telnet receive negotiator testbench
// Drives received bytes through the parser, predicts display, escape and
// reply transfers with flags, and checks each transfer on the result channel.
// ----------------------------------------------------------------------------
module tb_telnet_rx_option_negotiator;
   import trn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       pecho;
      logic       eoff;
      logic       cronly;
   } xfer_type;

   localparam logic [7:0] B_ESC = 8'h1B, B_SE = 8'hF0, B_SB = 8'hFA, B_WILL = 8'hFB;
   localparam logic [7:0] B_WONT = 8'hFC, B_DO = 8'hFD, B_DONT = 8'hFE;
   localparam logic [7:0] OPT_TTYPE = 8'h18, OPT_NAWS = 8'h1F, OPT_SPEED = 8'h20;
   localparam logic [7:0] OPT_LINEMODE = 8'h22, OPT_ENV = 8'h27;
   localparam logic [2:0] ADDR_COLS = 3'd0, ADDR_ROWS = 3'd4;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   trn_req_if req ();
   trn_rsp_if rsp ();

   telnet_rx_option_negotiator u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   logic [7:0] pending_bytes[$];
   xfer_type   expected_xfers[$];
   int         errors = 0;
   int         cycles = 0;
   int         src_idle_pct = 0, snk_idle_pct = 0;
   int         hold_cycles = 0;
   logic       src_pause = 1'b0;

   logic [7:0] cols, rows;
   logic [3:0] phase;
   logic [7:0] sub[3];
   logic [1:0] sub_cnt;
   logic       f_pecho, f_eoff, f_cronly;
   xfer_type   run_buf[$];

   function automatic void add(logic [1:0] k, logic [7:0] d);
      xfer_type x;
      x.kind = k; x.data = d; x.last = 1'b0;
      x.pecho = 1'b0; x.eoff = 1'b0; x.cronly = 1'b0;
      run_buf.push_back(x);
   endfunction

   function automatic void add3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      add(KIND_NET, a); add(KIND_NET, b); add(KIND_NET, c);
   endfunction

   function automatic logic [7:0] clamp_iac(logic [7:0] v);
      return (v == 8'hFF) ? 8'hFE : v;
   endfunction

   function automatic void sub_keep(logic [7:0] b);
      if (sub_cnt < 3) begin
         sub[sub_cnt] = b;
         sub_cnt++;
      end
   endfunction

   function automatic void reply_do(logic [7:0] opt);
      case (opt)
         8'h00: add3(IAC_BYTE, B_WILL, 8'h00);
         8'h01: begin
            f_eoff = 1'b1;
            add3(IAC_BYTE, B_WONT, 8'h01);
         end
         OPT_NAWS: begin
            add3(IAC_BYTE, B_SB, OPT_NAWS);
            add(KIND_NET, 8'h00); add(KIND_NET, clamp_iac(cols));
            add(KIND_NET, 8'h00); add(KIND_NET, clamp_iac(rows));
            add(KIND_NET, IAC_BYTE); add(KIND_NET, B_SE);
         end
         OPT_LINEMODE: for (int i = 0; i < 54; i++) add(KIND_NET, LMDO_TABLE[i]);
         8'h23, 8'h24: add3(IAC_BYTE, B_WONT, opt);
         default: ;
      endcase
   endfunction

   function automatic void reply_se();
      logic [7:0] s0, s1, s2;
      s0 = (sub_cnt > 0) ? sub[0] : 8'h00;
      s1 = (sub_cnt > 1) ? sub[1] : 8'h00;
      s2 = (sub_cnt > 2) ? sub[2] : 8'h00;
      if (s0 == OPT_TTYPE && s1 == 8'h01)
         for (int i = 0; i < 11; i++) add(KIND_NET, TTYPE_TABLE[i]);
      else if (s0 == OPT_SPEED && s1 == 8'h01)
         for (int i = 0; i < 17; i++) add(KIND_NET, SPEED_TABLE[i]);
      else if (s0 == OPT_LINEMODE && s1 == 8'h01 && s2 == 8'h13) begin
         f_cronly = 1'b1;
         for (int i = 0; i < 7; i++) add(KIND_NET, LMSB_TABLE[i]);
      end else if (s0 == OPT_ENV && s1 == 8'h01)
         for (int i = 0; i < 6; i++) add(KIND_NET, ENV_TABLE[i]);
   endfunction

   function automatic void predict_byte(logic [7:0] b);
      run_buf.delete();
      if (b inside {8'd8, 8'd10, 8'd11, 8'd13, 8'd14, 8'd15}) begin
         add(KIND_TEXT, b);
      end else begin
         case (phase)
            4'd1: begin
               add(KIND_ESC, b);
               case (b)
                  "[": phase = 4'd2;
                  "#": phase = 4'd10;
                  "(": phase = 4'd11;
                  ")": phase = 4'd12;
                  "7", "8", "E", "D", "M", ">", "=": phase = 4'd0;
                  default: ;
               endcase
            end
            4'd2: begin
               add(KIND_ESC, b);
               if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) phase = 4'd0;
            end
            4'd3: begin
               case (b)
                  B_WILL: phase = 4'd4;
                  B_WONT: phase = 4'd5;
                  B_DO: phase = 4'd6;
                  B_DONT: phase = 4'd7;
                  B_SB: begin
                     phase = 4'd8;
                     sub[0] = 0; sub[1] = 0; sub[2] = 0;
                     sub_cnt = 0;
                  end
                  IAC_BYTE: begin
                     phase = 4'd0;
                     add(KIND_TEXT, b);
                  end
                  default: phase = 4'd0;
               endcase
            end
            4'd4: begin
               phase = 4'd0;
               if (b == 8'h01) begin
                  f_pecho = 1'b1;
                  add3(IAC_BYTE, B_DO, 8'h01);
               end else if (b == 8'h03) add3(IAC_BYTE, B_DO, 8'h03);
            end
            4'd5: phase = 4'd0;
            4'd6: begin
               phase = 4'd0;
               reply_do(b);
            end
            4'd7: begin
               phase = 4'd0;
               if (b == OPT_LINEMODE) add3(IAC_BYTE, B_WONT, OPT_LINEMODE);
            end
            4'd8: if (b == IAC_BYTE) phase = 4'd9; else sub_keep(b);
            4'd9: begin
               if (b == B_SE) begin
                  phase = 4'd0;
                  reply_se();
               end else begin
                  phase = 4'd8;
                  if (b == IAC_BYTE) sub_keep(b);
               end
            end
            4'd10, 4'd11, 4'd12: begin
               phase = 4'd0;
               add(KIND_ESC, b);
            end
            default: begin
               if (b == B_ESC) begin
                  phase = 4'd1;
                  add(KIND_ESC, b);
               end else if (b == IAC_BYTE) phase = 4'd3;
               else begin
                  phase = 4'd0;
                  add(KIND_TEXT, b);
               end
            end
         endcase
      end
      foreach (run_buf[k]) begin
         run_buf[k].last = (k == run_buf.size() - 1);
         run_buf[k].pecho = f_pecho;
         run_buf[k].eoff = f_eoff;
         run_buf[k].cronly = f_cronly;
         expected_xfers.push_back(run_buf[k]);
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR: %0s got %0h expected %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.rx_byte <= '0;
      end else begin
         if (req.valid && req.ready) begin
            predict_byte(req.rx_byte);
            void'(pending_bytes.pop_front());
         end
         if ((!req.valid || req.ready) ) begin
            if (req.valid && req.ready && pending_bytes.size() == 0) req.valid <= 1'b0;
            else if (pending_bytes.size() > 0 && !src_pause
                     && $urandom_range(99) >= src_idle_pct) begin
               req.valid <= 1'b1;
               req.rx_byte <= (req.valid && req.ready) ? pending_bytes[0] : pending_bytes[0];
            end else req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_xfers.size() == 0) begin
               report_mismatch("unexpected transfer byte", rsp.out_byte, 0);
            end else begin
               xfer_type e;
               e = expected_xfers.pop_front();
               if (rsp.out_kind !== e.kind) report_mismatch("out_kind", rsp.out_kind, e.kind);
               if (rsp.out_byte !== e.data) report_mismatch("out_byte", rsp.out_byte, e.data);
               if (rsp.last_of_run !== e.last)
                  report_mismatch("last_of_run", rsp.last_of_run, e.last);
               if (rsp.peer_echoes !== e.pecho)
                  report_mismatch("peer_echoes", rsp.peer_echoes, e.pecho);
               if (rsp.local_echo_off !== e.eoff)
                  report_mismatch("local_echo_off", rsp.local_echo_off, e.eoff);
               if (rsp.cr_only_mode !== e.cronly)
                  report_mismatch("cr_only_mode", rsp.cr_only_mode, e.cronly);
            end
         end
         if (hold_cycles > 0) begin
            rsp.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
         end else rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [7:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr;
      csr_pwdata <= {24'h0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_COLS) cols = val; else rows = val;
   endtask

   task automatic drain();
      while (pending_bytes.size() > 0 || req.valid || expected_xfers.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic push_list(logic [7:0] l[$]);
      foreach (l[i]) pending_bytes.push_back(l[i]);
   endtask

   function automatic logic [7:0] rand_opt();
      logic [7:0] opts[9] = '{8'h00, 8'h01, 8'h03, OPT_NAWS, OPT_LINEMODE, 8'h23, 8'h24,
                              OPT_TTYPE, OPT_ENV};
      return ($urandom_range(3) == 0) ? 8'($urandom) : opts[$urandom_range(8)];
   endfunction

   task automatic queue_random(int count);
      int added;
      added = 0;
      while (added < count) begin
         case ($urandom_range(9))
            0, 1: begin
               pending_bytes.push_back(8'($urandom));
               added++;
            end
            2: begin
               push_list('{IAC_BYTE, 8'($urandom_range(8'hFB, 8'hFE)), rand_opt()});
               added += 3;
            end
            3: begin
               logic [7:0] s0;
               s0 = ($urandom_range(1)) ? OPT_LINEMODE : rand_opt();
               push_list('{IAC_BYTE, B_SB, s0, 8'($urandom_range(1)),
                           ($urandom_range(1)) ? 8'h13 : 8'($urandom)});
               if ($urandom_range(3) == 0) push_list('{IAC_BYTE, IAC_BYTE, 8'($urandom)});
               if ($urandom_range(3) == 0) push_list('{IAC_BYTE, 8'($urandom_range(0, 8'hEF))});
               push_list('{IAC_BYTE, B_SE});
               added += 7;
            end
            4: begin
               push_list('{B_ESC, "[", 8'($urandom_range(8'h30, 8'h39)), "m"});
               added += 4;
            end
            5: begin
               push_list('{B_ESC, 8'($urandom), 8'($urandom)});
               added += 3;
            end
            6: begin
               push_list('{IAC_BYTE, B_DO, ($urandom_range(1)) ? OPT_NAWS : rand_opt()});
               added += 3;
            end
            default: begin
               pending_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
               added++;
            end
         endcase
      end
   endtask

   initial begin
      cols = 8'd80; rows = 8'd24;
      phase = 0; sub[0] = 0; sub[1] = 0; sub[2] = 0; sub_cnt = 0;
      f_pecho = 0; f_eoff = 0; f_cronly = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      csr_write(ADDR_COLS, 8'd1);
      csr_write(ADDR_ROWS, 8'd254);
      src_idle_pct = 22; snk_idle_pct = 54;
      push_list('{8'h00, 8'h41, 8'hFF, 8'hFF, 8'd8, 8'd10, 8'd11, 8'd13, 8'd14, 8'd15});
      push_list('{B_ESC, "#", "8", B_ESC, "(", "B", B_ESC, ")", "0", B_ESC, "q", "7"});
      push_list('{B_ESC, "[", "1", 8'd10, "A", IAC_BYTE, 8'hF1});
      push_list('{IAC_BYTE, B_WILL, 8'h01, IAC_BYTE, B_WILL, 8'h03, IAC_BYTE, B_WONT, 8'h01});
      push_list('{IAC_BYTE, B_DO, 8'h00, IAC_BYTE, B_DO, 8'h01, IAC_BYTE, B_DO, OPT_NAWS});
      push_list('{IAC_BYTE, B_DO, OPT_LINEMODE, IAC_BYTE, B_DO, 8'h23, IAC_BYTE, B_DO, 8'h24});
      push_list('{IAC_BYTE, B_DONT, OPT_LINEMODE, IAC_BYTE, B_DONT, 8'h01});
      push_list('{IAC_BYTE, B_SB, OPT_TTYPE, 8'h01, IAC_BYTE, B_SE});
      push_list('{IAC_BYTE, B_SB, OPT_SPEED, 8'h01, 8'h55, 8'h66, IAC_BYTE, B_SE});
      push_list('{IAC_BYTE, B_SB, OPT_ENV, 8'h01, IAC_BYTE, 8'hF1, IAC_BYTE, B_SE});
      push_list('{IAC_BYTE, B_SB, OPT_LINEMODE, 8'h01, 8'h13, IAC_BYTE, B_SE});
      push_list('{IAC_BYTE, B_SB, OPT_LINEMODE, IAC_BYTE, IAC_BYTE, IAC_BYTE, B_SE});
      push_list('{IAC_BYTE, B_SB, IAC_BYTE, B_SE});
      drain();
      csr_write(ADDR_COLS, 8'd255);
      csr_write(ADDR_ROWS, 8'd0);
      push_list('{IAC_BYTE, B_DO, OPT_NAWS});
      queue_random(30);
      hold_cycles <= 200;
      drain();
      src_pause = 1'b1;
      repeat (20) @(posedge clock);
      src_pause = 1'b0;
      csr_write(ADDR_COLS, 8'd254);
      csr_write(ADDR_ROWS, 8'd1);
      src_idle_pct = 54; snk_idle_pct = 22;
      push_list('{IAC_BYTE, B_DO, OPT_NAWS});
      queue_random(30);
      drain();
      csr_write(ADDR_COLS, 8'($urandom_range(1, 254)));
      csr_write(ADDR_ROWS, 8'($urandom_range(1, 254)));
      src_idle_pct = 0; snk_idle_pct = 0;
      push_list('{IAC_BYTE, B_DO, OPT_NAWS});
      queue_random(30);
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

@@ telnet_rx_option_negotiator.f @@
+incdir+rtl
rtl/trn_pkg.sv
rtl/trn_req_if.sv
rtl/trn_rsp_if.sv
rtl/trn_parser.sv
rtl/trn_cmd_queue.sv
rtl/trn_reply_seq.sv
rtl/telnet_rx_option_negotiator.sv
tb/sv/tb_telnet_rx_option_negotiator.sv
